/* hdl/shc_pkg.sv */
// Types, codes and small helper functions shared by the settable clock modules.
`default_nettype none

package shc_pkg;

    localparam logic [3:0] BLANK_CODE = 4'd11;

    localparam logic [3:0] KEY_UP    = 4'd11;
    localparam logic [3:0] KEY_DOWN  = 4'd10;
    localparam logic [3:0] KEY_RIGHT = 4'd8;
    localparam logic [3:0] KEY_LEFT  = 4'd7;
    localparam logic [3:0] KEY_RUN   = 4'd0;
    localparam logic [3:0] KEY_STOP  = 4'd9;
    localparam logic [3:0] KEY_CLEAR = 4'd1;

    // Register indexes on the configuration port.
    localparam logic REG_POLLS_PER_SECOND = 1'b0;
    localparam logic REG_EDIT_TIMEOUT     = 1'b1;

    localparam logic [3:0] POLLS_PER_SECOND_RESET = 4'd10;
    localparam logic [3:0] EDIT_TIMEOUT_RESET     = 4'd10;

    localparam logic [4:0] HOURS_RESET   = 5'd23;
    localparam logic [5:0] MINUTES_RESET = 6'd59;
    localparam logic [5:0] SECONDS_RESET = 6'd55;

    localparam logic [4:0] HOURS_LAST   = 5'd23;
    localparam logic [5:0] MINUTES_LAST = 6'd59;
    localparam logic [5:0] SECONDS_LAST = 6'd59;
    localparam logic [5:0] HOURS_WRAP   = 6'd24;
    localparam logic [5:0] MINUTES_WRAP = 6'd60;

    typedef enum logic [1:0] {
        FIELD_NONE    = 2'd0,
        FIELD_HOURS   = 2'd1,
        FIELD_MINUTES = 2'd2,
        FIELD_SECONDS = 2'd3
    } edit_field_t;

    typedef struct packed {
        logic [3:0] polls_per_second;
        logic [3:0] edit_timeout;
    } cfg_t;

    typedef struct packed {
        logic [3:0] hour_tens;
        logic [3:0] hour_units;
        logic [3:0] minute_tens;
        logic [3:0] minute_units;
        logic [3:0] second_tens;
        logic [3:0] second_units;
        logic [5:0] dot_mask;
    } result_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } digit_pair_t;

    // Splits a value below 64 into two decimal digits by a short compare chain.
    function automatic digit_pair_t split_digits(input logic [5:0] value);
        digit_pair_t d;
        logic [5:0]  tens_x10;
        if (value >= 6'd60)      d.tens = 4'd6;
        else if (value >= 6'd50) d.tens = 4'd5;
        else if (value >= 6'd40) d.tens = 4'd4;
        else if (value >= 6'd30) d.tens = 4'd3;
        else if (value >= 6'd20) d.tens = 4'd2;
        else if (value >= 6'd10) d.tens = 4'd1;
        else                     d.tens = 4'd0;
        tens_x10 = {d.tens[2:0], 3'b000} + {2'b00, d.tens[2:0], 1'b0};
        d.units  = 4'(value - tens_x10);
        return d;
    endfunction

    function automatic logic [5:0] dots_of(input edit_field_t f);
        logic [5:0] m;
        unique case (f)
            FIELD_HOURS:   m = 6'h30;
            FIELD_MINUTES: m = 6'h0C;
            FIELD_SECONDS: m = 6'h03;
            default:       m = 6'h00;
        endcase
        return m;
    endfunction

    function automatic edit_field_t right_of(input edit_field_t f);
        edit_field_t r;
        unique case (f)
            FIELD_MINUTES: r = FIELD_SECONDS;
            FIELD_SECONDS: r = FIELD_HOURS;
            default:       r = FIELD_MINUTES;
        endcase
        return r;
    endfunction

    function automatic edit_field_t left_of(input edit_field_t f);
        edit_field_t r;
        unique case (f)
            FIELD_MINUTES: r = FIELD_HOURS;
            FIELD_SECONDS: r = FIELD_MINUTES;
            default:       r = FIELD_SECONDS;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/shc_core.sv */
// Clock state and the update that one keypad poll causes.
`default_nettype none

module shc_core
    import shc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic       key_pressed,
    input  wire logic [3:0] key_id,
    input  wire cfg_t       cfg,
    output result_t         result
);

    logic [4:0]  hours_reg,      hours_next;
    logic [5:0]  minutes_reg,    minutes_next;
    logic [5:0]  seconds_reg,    seconds_next;
    logic        running_reg,    running_next;
    edit_field_t edit_field_reg, edit_field_next;
    logic [3:0]  idle_count_reg, idle_count_next;
    logic        blink_reg,      blink_next;
    logic [3:0]  poll_count_reg, poll_count_next;
    logic        last_pressed_reg, last_pressed_next;
    logic [3:0]  last_key_reg,   last_key_next;
    logic [5:0]  dots_reg,       dots_next;

    logic [4:0]  hr_t;
    logic [5:0]  min_t;
    logic [5:0]  sec_t;
    logic [3:0]  poll_inc;
    logic [3:0]  idle_a;
    edit_field_t field_a;
    logic [5:0]  dots_a;
    logic        changed;
    logic        blank;
    logic [5:0]  field_val;
    logic [5:0]  field_wrap;
    logic [6:0]  field_inc;
    logic [5:0]  field_new;
    digit_pair_t hr_d;
    digit_pair_t min_d;
    digit_pair_t sec_d;

    always_comb
    begin
        // Clock tick on the first poll of each second, while the clock runs.
        hr_t  = hours_reg;
        min_t = minutes_reg;
        sec_t = seconds_reg;
        if (running_reg && poll_count_reg == 4'd0)
        begin
            if (seconds_reg >= SECONDS_LAST)
            begin
                sec_t = 6'd0;
                if (minutes_reg >= MINUTES_LAST)
                begin
                    min_t = 6'd0;
                    hr_t  = (hours_reg >= HOURS_LAST) ? 5'd0 : hours_reg + 5'd1;
                end
                else
                begin
                    min_t = minutes_reg + 6'd1;
                end
            end
            else
            begin
                sec_t = seconds_reg + 6'd1;
            end
        end

        // A zero setting leaves the 4-bit counter to wrap, so a second is 16 polls.
        poll_inc = poll_count_reg + 4'd1;
        if (cfg.polls_per_second != 4'd0 && poll_inc >= cfg.polls_per_second)
            poll_count_next = 4'd0;
        else
            poll_count_next = poll_inc;

        blank  = !blink_reg && edit_field_reg != FIELD_NONE;
        idle_a = idle_count_reg;
        if (!blink_reg)
            idle_a = (edit_field_reg != FIELD_NONE) ? idle_count_reg + 4'd1 : 4'd0;
        blink_next = !blink_reg;

        field_a = edit_field_reg;
        dots_a  = dots_reg;
        if (idle_a == cfg.edit_timeout)
        begin
            idle_a  = 4'd0;
            field_a = FIELD_NONE;
            dots_a  = 6'd0;
        end

        changed = (key_pressed != last_pressed_reg)
               || (key_pressed && key_id != last_key_reg);

        case (field_a)
            FIELD_HOURS:   field_val = {1'b0, hr_t};
            FIELD_MINUTES: field_val = min_t;
            default:       field_val = sec_t;
        endcase
        field_wrap = (field_a == FIELD_HOURS) ? HOURS_WRAP : MINUTES_WRAP;
        field_inc  = {1'b0, field_val} + 7'd1;
        if (key_id == KEY_UP)
            field_new = (field_inc >= {1'b0, field_wrap}) ? 6'd0 : field_inc[5:0];
        else
            field_new = (field_val == 6'd0 || field_val > field_wrap)
                      ? field_wrap - 6'd1 : field_val - 6'd1;

        hours_next        = hr_t;
        minutes_next      = min_t;
        seconds_next      = sec_t;
        running_next      = running_reg;
        edit_field_next   = field_a;
        idle_count_next   = idle_a;
        dots_next         = dots_a;
        last_pressed_next = last_pressed_reg;
        last_key_next     = last_key_reg;

        if (changed)
        begin
            last_pressed_next = key_pressed;
            last_key_next     = key_id;
            if (key_pressed)
            begin
                case (key_id) inside
                    KEY_UP, KEY_DOWN:
                    begin
                        idle_count_next = 4'd0;
                        case (field_a)
                            FIELD_HOURS:   hours_next   = field_new[4:0];
                            FIELD_MINUTES: minutes_next = field_new;
                            FIELD_SECONDS: seconds_next = field_new;
                            default:       ;
                        endcase
                    end
                    KEY_RIGHT:
                    begin
                        idle_count_next = 4'd0;
                        edit_field_next = right_of(field_a);
                        dots_next       = dots_of(right_of(field_a));
                    end
                    KEY_LEFT:
                    begin
                        idle_count_next = 4'd0;
                        edit_field_next = left_of(field_a);
                        dots_next       = dots_of(left_of(field_a));
                    end
                    KEY_RUN:  running_next = 1'b1;
                    KEY_STOP: running_next = 1'b0;
                    KEY_CLEAR:
                    begin
                        hours_next   = 5'd0;
                        minutes_next = 6'd0;
                        seconds_next = 6'd0;
                    end
                    default: ;
                endcase
            end
        end

        // Digits are shown as refreshed after the tick and before the key.
        hr_d  = split_digits({1'b0, hr_t});
        min_d = split_digits(min_t);
        sec_d = split_digits(sec_t);
        result.hour_tens    = (blank && edit_field_reg == FIELD_HOURS)   ? BLANK_CODE : hr_d.tens;
        result.hour_units   = (blank && edit_field_reg == FIELD_HOURS)   ? BLANK_CODE : hr_d.units;
        result.minute_tens  = (blank && edit_field_reg == FIELD_MINUTES) ? BLANK_CODE : min_d.tens;
        result.minute_units = (blank && edit_field_reg == FIELD_MINUTES) ? BLANK_CODE : min_d.units;
        result.second_tens  = (blank && edit_field_reg == FIELD_SECONDS) ? BLANK_CODE : sec_d.tens;
        result.second_units = (blank && edit_field_reg == FIELD_SECONDS) ? BLANK_CODE : sec_d.units;
        result.dot_mask     = dots_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hours_reg        <= HOURS_RESET;
            minutes_reg      <= MINUTES_RESET;
            seconds_reg      <= SECONDS_RESET;
            running_reg      <= 1'b1;
            edit_field_reg   <= FIELD_NONE;
            idle_count_reg   <= 4'd0;
            blink_reg        <= 1'b0;
            poll_count_reg   <= 4'd0;
            last_pressed_reg <= 1'b0;
            last_key_reg     <= 4'd0;
            dots_reg         <= 6'd0;
        end
        else if (step)
        begin
            hours_reg        <= hours_next;
            minutes_reg      <= minutes_next;
            seconds_reg      <= seconds_next;
            running_reg      <= running_next;
            edit_field_reg   <= edit_field_next;
            idle_count_reg   <= idle_count_next;
            blink_reg        <= blink_next;
            poll_count_reg   <= poll_count_next;
            last_pressed_reg <= last_pressed_next;
            last_key_reg     <= last_key_next;
            dots_reg         <= dots_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/settable_hms_clock.sv */
// Top level of the settable hours-minutes-seconds clock: handshakes, registers, result queue.
`default_nettype none

// Each request is one keypad poll and yields one result with the six shown
// digits and the decimal point mask. One request is taken every clock cycle
// while results are drained: a request is held in the input register, the
// clock state is updated in a single pass as it leaves that register, and the
// result goes into a two-entry queue whose head drives the output ports. The
// queue lets the next request be taken while a finished result still waits.
// polls_per_second (address 0) and edit_timeout (address 4) are written over
// the APB port; the user must write them only while no request is in flight,
// as the block itself does not enforce it.
module settable_hms_clock
    import shc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        key_pressed,
    input  wire logic [3:0]  key_id,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [3:0]  hour_tens,
    output logic      [3:0]  hour_units,
    output logic      [3:0]  minute_tens,
    output logic      [3:0]  minute_units,
    output logic      [3:0]  second_tens,
    output logic      [3:0]  second_units,
    output logic      [5:0]  dot_mask
);

    cfg_t       cfg_reg;
    logic       s1_valid_reg;
    logic       s1_pressed_reg;
    logic [3:0] s1_code_reg;
    logic [1:0] count_reg;
    result_t    head_reg;
    result_t    tail_reg;
    result_t    new_result;
    logic       s1_go;
    logic       pop;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_POLLS_PER_SECOND: prdata = {28'd0, cfg_reg.polls_per_second};
            REG_EDIT_TIMEOUT:     prdata = {28'd0, cfg_reg.edit_timeout};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.polls_per_second <= POLLS_PER_SECOND_RESET;
            cfg_reg.edit_timeout     <= EDIT_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_POLLS_PER_SECOND: cfg_reg.polls_per_second <= pwdata[3:0];
                REG_EDIT_TIMEOUT:     cfg_reg.edit_timeout     <= pwdata[3:0];
                default:              ;
            endcase
        end
    end

    assign out_valid = count_reg != 2'd0;
    assign pop       = out_valid && out_ready;
    assign s1_go     = s1_valid_reg && (count_reg != 2'd2 || out_ready);
    assign in_ready  = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_pressed_reg <= key_pressed;
            s1_code_reg    <= key_id;
        end
    end

    shc_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_go),
        .key_pressed (s1_pressed_reg),
        .key_id      (s1_code_reg),
        .cfg         (cfg_reg),
        .result      (new_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else if (s1_go && !pop)
            count_reg <= count_reg + 2'd1;
        else if (pop && !s1_go)
            count_reg <= count_reg - 2'd1;
    end

    // The head entry drives the ports; the tail only fills while an older result is left in the head.
    always_ff @(posedge clk)
    begin
        if (s1_go && !pop)
        begin
            if (count_reg == 2'd0)
                head_reg <= new_result;
            else
                tail_reg <= new_result;
        end
        else if (pop && !s1_go)
        begin
            head_reg <= tail_reg;
        end
        else if (pop && s1_go)
        begin
            if (count_reg == 2'd1)
                head_reg <= new_result;
            else
            begin
                head_reg <= tail_reg;
                tail_reg <= new_result;
            end
        end
    end

    assign hour_tens    = head_reg.hour_tens;
    assign hour_units   = head_reg.hour_units;
    assign minute_tens  = head_reg.minute_tens;
    assign minute_units = head_reg.minute_units;
    assign second_tens  = head_reg.second_tens;
    assign second_units = head_reg.second_units;
    assign dot_mask     = head_reg.dot_mask;

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("result queue holds more than two entries");

    assert property (@(posedge clk) disable iff (!rst_n) s1_go |=> out_valid)
        else $error("processed request left no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hour_tens <= 4'd2 || hour_tens == BLANK_CODE)
                   && (minute_tens <= 4'd5 || minute_tens == BLANK_CODE)
                   && (second_tens <= 4'd5 || second_tens == BLANK_CODE))
        else $error("tens digit out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted request not held in input register");

endmodule

`default_nettype wire

/* bench/clock_face_checker.sv */
// Watches the settable clock's channels and register port, predicts each result and compares.
module clock_face_checker
    import shc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        key_pressed,
    input  logic [3:0]  key_id,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  hour_tens,
    input  logic [3:0]  hour_units,
    input  logic [3:0]  minute_tens,
    input  logic [3:0]  minute_units,
    input  logic [3:0]  second_tens,
    input  logic [3:0]  second_units,
    input  logic [5:0]  dot_mask,
    output int unsigned mismatches,
    output int unsigned waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOURS_PER_DAY      = 24;
    localparam int MINUTES_PER_HOUR   = 60;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int PRINT_CAP          = 50;

    // Predicted clock state and register copies.
    logic [4:0]  hrs;
    logic [5:0]  mins;
    logic [5:0]  secs;
    logic        ticking;
    edit_field_t field;
    logic [3:0]  idle_polls;
    logic        blink;
    logic [3:0]  poll_idx;
    logic        held_pressed;
    logic [3:0]  held_code;
    logic [5:0]  dots_now;
    logic [3:0]  cfg_pps;
    logic [3:0]  cfg_timeout;

    result_t expected_faces[$];

    initial mismatches = 0;

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("%0t ns clock_face_checker: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [5:0] got,
                               input logic [5:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Raises or lowers the field under edit, wrapping at its own modulus.
    task automatic nudge_field(input logic raise);
        int v;
        int w;
        case (field)
            FIELD_HOURS:   begin v = hrs;  w = HOURS_PER_DAY;      end
            FIELD_MINUTES: begin v = mins; w = MINUTES_PER_HOUR;   end
            default:       begin v = secs; w = SECONDS_PER_MINUTE; end
        endcase
        if (raise)
            v = (v + 1 >= w) ? 0 : v + 1;
        else
            v = (v == 0 || v > w) ? w - 1 : v - 1;
        case (field)
            FIELD_HOURS:   hrs  = 5'(v);
            FIELD_MINUTES: mins = 6'(v);
            default:       secs = 6'(v);
        endcase
    endtask

    // One keypad poll: tick, show the digits, blink and timeout, then the key.
    task automatic step_clock(input logic pressed, input logic [3:0] code,
                              output result_t face);
        logic [3:0] nxt;
        logic       fresh;
        if (poll_idx == 4'd0 && ticking) begin
            secs = secs + 6'd1;
            if (secs >= SECONDS_PER_MINUTE) begin
                secs = 6'd0;
                mins = mins + 6'd1;
                if (mins >= MINUTES_PER_HOUR) begin
                    mins = 6'd0;
                    hrs  = hrs + 5'd1;
                    if (hrs >= HOURS_PER_DAY)
                        hrs = 5'd0;
                end
            end
        end
        nxt = poll_idx + 4'd1;
        if (cfg_pps != 4'd0 && nxt >= cfg_pps)
            nxt = 4'd0;
        poll_idx = nxt;

        face.hour_tens    = 4'(hrs / 10);
        face.hour_units   = 4'(hrs % 10);
        face.minute_tens  = 4'(mins / 10);
        face.minute_units = 4'(mins % 10);
        face.second_tens  = 4'(secs / 10);
        face.second_units = 4'(secs % 10);
        if (!blink) begin
            if (field != FIELD_NONE) begin
                idle_polls = idle_polls + 4'd1;
                case (field)
                    FIELD_HOURS: begin
                        face.hour_tens  = BLANK_CODE;
                        face.hour_units = BLANK_CODE;
                    end
                    FIELD_MINUTES: begin
                        face.minute_tens  = BLANK_CODE;
                        face.minute_units = BLANK_CODE;
                    end
                    default: begin
                        face.second_tens  = BLANK_CODE;
                        face.second_units = BLANK_CODE;
                    end
                endcase
            end else begin
                idle_polls = 4'd0;
            end
        end
        blink = ~blink;

        if (idle_polls == cfg_timeout) begin
            idle_polls = 4'd0;
            field      = FIELD_NONE;
            dots_now   = 6'h00;
        end

        // Only a change of key since the previous poll does anything.
        fresh = (pressed != held_pressed) || (pressed && code != held_code);
        if (fresh) begin
            held_pressed = pressed;
            held_code    = code;
            if (pressed) begin
                case (code) inside
                    KEY_UP, KEY_DOWN: begin
                        idle_polls = 4'd0;
                        if (field != FIELD_NONE)
                            nudge_field(code == KEY_UP);
                    end
                    KEY_RIGHT, KEY_LEFT: begin
                        idle_polls = 4'd0;
                        case (field)
                            FIELD_MINUTES:
                                field = (code == KEY_RIGHT) ? FIELD_SECONDS : FIELD_HOURS;
                            FIELD_SECONDS:
                                field = (code == KEY_RIGHT) ? FIELD_HOURS : FIELD_MINUTES;
                            default:
                                field = (code == KEY_RIGHT) ? FIELD_MINUTES : FIELD_SECONDS;
                        endcase
                        case (field)
                            FIELD_HOURS:   dots_now = 6'h30;
                            FIELD_MINUTES: dots_now = 6'h0C;
                            default:       dots_now = 6'h03;
                        endcase
                    end
                    KEY_RUN:   ticking = 1'b1;
                    KEY_STOP:  ticking = 1'b0;
                    KEY_CLEAR: begin
                        hrs  = 5'd0;
                        mins = 6'd0;
                        secs = 6'd0;
                    end
                    default: ;
                endcase
            end
        end
        face.dot_mask = dots_now;
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t     got;
        result_t     want;
        logic [31:0] reg_want;
        if (!rst_n) begin
            hrs          = HOURS_RESET;
            mins         = MINUTES_RESET;
            secs         = SECONDS_RESET;
            ticking      = 1'b1;
            field        = FIELD_NONE;
            idle_polls   = 4'd0;
            blink        = 1'b0;
            poll_idx     = 4'd0;
            held_pressed = 1'b0;
            held_code    = 4'd0;
            dots_now     = 6'h00;
            cfg_pps      = POLLS_PER_SECOND_RESET;
            cfg_timeout  = EDIT_TIMEOUT_RESET;
            expected_faces.delete();
            waiting <= 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_EDIT_TIMEOUT)
                        cfg_timeout = pwdata[3:0];
                    else
                        cfg_pps = pwdata[3:0];
                end else begin
                    reg_want = (paddr[2] == REG_EDIT_TIMEOUT) ? {28'd0, cfg_timeout}
                                                              : {28'd0, cfg_pps};
                    if (prdata !== reg_want)
                        report_mismatch($sformatf("register at %0d reads %0d, expected %0d",
                                                  paddr, prdata, reg_want));
                end
            end

            if (out_valid && out_ready) begin
                got = {hour_tens, hour_units, minute_tens, minute_units,
                       second_tens, second_units, dot_mask};
                if (expected_faces.size() == 0) begin
                    report_mismatch("result arrived with no request outstanding");
                end else begin
                    want = expected_faces.pop_front();
                    check_field("hour_tens", got.hour_tens, want.hour_tens);
                    check_field("hour_units", got.hour_units, want.hour_units);
                    check_field("minute_tens", got.minute_tens, want.minute_tens);
                    check_field("minute_units", got.minute_units, want.minute_units);
                    check_field("second_tens", got.second_tens, want.second_tens);
                    check_field("second_units", got.second_units, want.second_units);
                    check_field("dot_mask", got.dot_mask, want.dot_mask);
                end
            end

            if (in_valid && in_ready) begin
                step_clock(key_pressed, key_id, want);
                expected_faces.push_back(want);
            end
            waiting <= expected_faces.size();
        end
    end

endmodule

/* bench/settable_hms_clock_test.sv */
// Top of the settable clock testbench: clock, reset, keypad polls, register writes and verdict.
module settable_hms_clock_test;
    timeunit 1ns;
    timeprecision 1ps;
    import shc_pkg::*;

    localparam logic [2:0]  PPS_ADDR     = {REG_POLLS_PER_SECOND, 2'b00};
    localparam logic [2:0]  TIMEOUT_ADDR = {REG_EDIT_TIMEOUT, 2'b00};
    localparam int unsigned DRAIN_LIMIT  = 2000;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned PHASES       = 7;
    localparam int unsigned PHASE_POLLS  = 135;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        key_pressed;
    logic [3:0]  key_id;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  hour_tens;
    logic [3:0]  hour_units;
    logic [3:0]  minute_tens;
    logic [3:0]  minute_units;
    logic [3:0]  second_tens;
    logic [3:0]  second_units;
    logic [5:0]  dot_mask;
    int unsigned mismatches;
    int unsigned waiting;

    int unsigned burst_left = 0;
    bit          gaps_on    = 1'b1;
    logic        stalls_on  = 1'b1;
    int unsigned stall_left = 0;
    int unsigned run_left   = 0;
    logic        stuck;

    settable_hms_clock i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .key_pressed  (key_pressed),
        .key_id       (key_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hour_tens    (hour_tens),
        .hour_units   (hour_units),
        .minute_tens  (minute_tens),
        .minute_units (minute_units),
        .second_tens  (second_tens),
        .second_units (second_units),
        .dot_mask     (dot_mask)
    );

    clock_face_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .key_pressed  (key_pressed),
        .key_id       (key_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hour_tens    (hour_tens),
        .hour_units   (hour_units),
        .minute_tens  (minute_tens),
        .minute_units (minute_units),
        .second_tens  (second_tens),
        .second_units (second_units),
        .dot_mask     (dot_mask),
        .mismatches   (mismatches),
        .waiting      (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The result side takes runs of results, broken by short stalls when enabled.
    always @(posedge clk)
    begin
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (run_left != 0) begin
            out_ready <= 1'b1;
            run_left  <= run_left - 1;
        end else begin
            out_ready  <= 1'b1;
            run_left   <= $urandom_range(1, 24);
            stall_left <= stalls_on ? $urandom_range(1, 6) : 0;
        end
    end

    task automatic send_poll(input logic pressed, input logic [3:0] code);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        key_pressed <= pressed;
        key_id      <= code;
        do @(posedge clk); while (!in_ready);
    endtask

    // Ends with psel and penable low before returning, so that a following access starts cleanly.
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained(output logic timed_out);
        int unsigned n;
        n = 0;
        @(posedge clk);
        while (waiting != 0 && n < DRAIN_LIMIT) begin
            @(posedge clk);
            n++;
        end
        timed_out = (waiting != 0);
    endtask

    // Mostly the keys that edit and run the clock, now and then any code at all.
    function automatic logic [3:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r <= 3)       return KEY_UP;
        else if (r <= 6)  return KEY_DOWN;
        else if (r <= 8)  return KEY_RIGHT;
        else if (r <= 10) return KEY_LEFT;
        else if (r == 11) return KEY_RUN;
        else if (r == 12) return KEY_STOP;
        else if (r == 13) return KEY_CLEAR;
        return 4'($urandom);
    endfunction

    // Presses held for a few polls and released, with the odd long pause so that
    // edit mode can time out, some key changes without release, and some noise.
    task automatic play_keys(input int unsigned polls);
        int unsigned sent;
        int unsigned hold;
        int unsigned pause;
        int unsigned kind;
        logic [3:0]  code;
        sent = 0;
        while (sent < polls) begin
            kind = $urandom_range(0, 9);
            if (kind == 7) begin
                hold = $urandom_range(1, 6);
                repeat (hold) begin
                    send_poll(1'($urandom), 4'($urandom));
                    sent++;
                end
            end else begin
                code = pick_key();
                hold = $urandom_range(1, 4);
                repeat (hold) begin
                    send_poll(1'b1, code);
                    sent++;
                end
                if (kind != 9) begin
                    pause = (kind == 8) ? $urandom_range(20, 40) : $urandom_range(1, 4);
                    repeat (pause) begin
                        send_poll(1'b0, 4'($urandom));
                        sent++;
                    end
                end
            end
        end
    endtask

    initial
    begin
        int unsigned ph;
        logic [3:0]  pps;
        logic [3:0]  timeout;
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        key_pressed <= 1'b0;
        key_id      <= '0;
        stuck        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < PHASES && !stuck; ph++) begin
            gaps_on    = (ph % 3 != 2);
            stalls_on <= (ph % 3 != 1);
            case (ph)
                1:       begin pps = 4'd1;  timeout = 4'd1;  end
                2:       begin pps = 4'd15; timeout = 4'd15; end
                3:       begin pps = 4'd0;  timeout = 4'd0;  end
                4:       begin pps = 4'($urandom_range(1, 15)); timeout = 4'($urandom_range(1, 15)); end
                5:       begin pps = 4'($urandom); timeout = 4'($urandom); end
                default: begin pps = POLLS_PER_SECOND_RESET; timeout = EDIT_TIMEOUT_RESET; end
            endcase
            if (ph != 0) begin
                apb_access(1'b1, PPS_ADDR, {28'd0, pps});
                apb_access(1'b1, TIMEOUT_ADDR, {28'd0, timeout});
            end
            apb_access(1'b0, PPS_ADDR, '0);
            apb_access(1'b0, TIMEOUT_ADDR, '0);

            if (ph == 0) begin
                // Keys with no field selected, then every field raised and lowered, hours
                // and minutes through their wrap, a held key, stop, clear, run and unused codes.
                send_poll(1'b0, 4'($urandom));
                send_poll(1'b1, KEY_UP);
                send_poll(1'b1, KEY_UP);
                send_poll(1'b0, 4'hF);
                send_poll(1'b1, KEY_DOWN);
                send_poll(1'b1, KEY_RIGHT);
                send_poll(1'b1, KEY_UP);
                send_poll(1'b1, KEY_DOWN);
                send_poll(1'b1, KEY_LEFT);
                send_poll(1'b1, KEY_UP);
                send_poll(1'b1, KEY_DOWN);
                send_poll(1'b1, KEY_LEFT);
                send_poll(1'b1, KEY_UP);
                send_poll(1'b1, KEY_DOWN);
                send_poll(1'b1, KEY_RIGHT);
                send_poll(1'b1, KEY_STOP);
                send_poll(1'b1, KEY_CLEAR);
                send_poll(1'b1, KEY_DOWN);
                send_poll(1'b0, 4'($urandom));
                send_poll(1'b1, KEY_RUN);
                send_poll(1'b1, 4'd2);
                send_poll(1'b1, 4'd15);
                send_poll(1'b0, 4'd15);
            end
            play_keys(PHASE_POLLS);
            in_valid <= 1'b0;
            wait_drained(stuck);
        end

        if (!stuck)
            repeat (SETTLE) @(posedge clk);
        if (!stuck && mismatches == 0)
            $display("settable_hms_clock_test: done, clean");
        else
            $display("settable_hms_clock_test: done, errors");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("settable_hms_clock_test: done, errors");
        $finish;
    end

endmodule
